// File: rtl/sdnf_pkg.sv
// Shared types, codes and constants of the segment display number formatter.
package sdnf_pkg;

  // Decimal digits of a 32-bit value; also the number of digit stages.
  localparam int unsigned NDIG = 10;
  localparam int unsigned DIG_BITS = 4 * NDIG;
  localparam int unsigned NDIG_W = 4;
  // Hex digit count after clamping, up to the largest display width.
  localparam int unsigned CNT_W = 5;

  localparam int unsigned DEF_WIDTH = 6;
  localparam int unsigned DEF_HAS_DOTS = 1;

  // Divide by ten: multiply by the reciprocal and shift.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [6:0] GLYPH_SPACE = 7'h20;
  localparam logic [6:0] GLYPH_MINUS = 7'h2D;
  localparam logic [6:0] GLYPH_ZERO = 7'h30;
  localparam logic [6:0] GLYPH_NINE = 7'h39;
  localparam logic [6:0] GLYPH_A = 7'h41;

  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_FIXED    = 2'd2,
    OP_HEX      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DOT_LEAVE = 2'd0,
    DOT_CLEAR = 2'd1,
    DOT_LIGHT = 2'd2
  } dot_act_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] value_bits;
    logic [7:0]  decimals;
    logic [7:0]  hex_digits;
  } in_item_t;

  typedef struct packed {
    logic [2:0] cell_index;
    logic [6:0] glyph;
    logic [1:0] dot_action;
    logic [2:0] dot_index;
    logic       last;
  } out_item_t;

  // Work carried down the digit pipeline.
  typedef struct packed {
    op_t                 op;
    logic                neg;
    logic [7:0]          dec;
    logic [CNT_W-1:0]    hexn;
    logic [31:0]         hex_val;
    logic [31:0]         rem;
    logic [DIG_BITS-1:0] digits;
    logic [NDIG_W-1:0]   ndig;
  } work_t;

endpackage

// File: rtl/segment_display_number_formatter.sv
// Number formatter for a segment display: input register, digit pipeline,
// layout stage and cell serializer.
//
// The in channel takes one number per transaction: a mode, a 32-bit value,
// a decimals count and a hex digit count. The out channel gives WIDTH
// transactions per number, cell 0 (leftmost) first, each with its glyph;
// cell 0 carries the dot command and the rightmost cell has last set.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// The first cell of a number is offered after the input register, ten digit
// stages, layout stage and serializer register; the cells then follow one per
// cycle while out_stall is low. The serializer takes a new number only once
// the previous one has sent its last cell. Up to twelve numbers wait in the
// pipeline behind it, so in_stall rises only when all stages are full.
// Reset (rst, synchronous) empties every stage; out_valid drops.
// When the receiver stalls, the current cell holds and the pipeline fills,
// then stalls the sender; nothing is lost or repeated.
module segment_display_number_formatter #(
  parameter int unsigned WIDTH = sdnf_pkg::DEF_WIDTH,
  parameter int unsigned HAS_DOTS = sdnf_pkg::DEF_HAS_DOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdnf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sdnf_pkg::out_item_t out_data
);
  import sdnf_pkg::*;

  localparam int unsigned CIDX_W = $clog2(WIDTH);
  localparam logic [7:0] W8 = 8'(WIDTH);
  localparam logic [CIDX_W-1:0] LAST_CELL = CIDX_W'(WIDTH - 1);

  // Input register
  logic  in_reg_valid;
  work_t in_reg;
  work_t in_reg_next;
  logic  in_reg_stall;

  // Digit pipeline links: entry k feeds digit stage k.
  logic  pipe_valid [NDIG+1];
  logic  pipe_stall [NDIG+1];
  work_t pipe_data [NDIG+1];

  // Layout stage output
  logic                  fmt_valid;
  logic                  fmt_stall;
  logic [WIDTH-1:0][6:0] fmt_cells;
  logic [1:0]            fmt_act;
  logic [2:0]            fmt_dix;

  // Serializer
  logic                  busy;
  logic [CIDX_W-1:0]     cnt;
  logic [WIDTH-1:0][6:0] cells;
  logic [1:0]            act;
  logic [2:0]            dix;
  logic                  out_fire;
  logic                  done;
  logic                  load;

  always_comb begin
    logic neg;
    neg = (in_data.operation == OP_SIGNED || in_data.operation == OP_FIXED)
          && in_data.value_bits[31];
    in_reg_next.op = op_t'(in_data.operation);
    in_reg_next.neg = neg;
    in_reg_next.dec = in_data.decimals;
    if (in_data.hex_digits == 8'd0) begin
      in_reg_next.hexn = CNT_W'(1);
    end else if (in_data.hex_digits > W8) begin
      in_reg_next.hexn = CNT_W'(WIDTH);
    end else begin
      in_reg_next.hexn = CNT_W'(in_data.hex_digits);
    end
    in_reg_next.hex_val = in_data.value_bits;
    in_reg_next.rem = neg ? (~in_data.value_bits + 32'd1) : in_data.value_bits;
    in_reg_next.digits = '0;
    in_reg_next.ndig = NDIG_W'(1);
  end

  assign in_reg_stall = in_reg_valid && pipe_stall[0];
  assign in_stall = in_reg_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_reg_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_reg_stall && in_valid) begin
      in_reg <= in_reg_next;
    end
  end

  assign pipe_valid[0] = in_reg_valid;
  assign pipe_data[0] = in_reg;

  for (genvar k = 0; k < NDIG; k++) begin : g_digit
    sdnf_digit_stage #(
      .POS(k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (pipe_valid[k]),
      .up_stall (pipe_stall[k]),
      .up_data  (pipe_data[k]),
      .dn_valid (pipe_valid[k+1]),
      .dn_stall (pipe_stall[k+1]),
      .dn_data  (pipe_data[k+1])
    );
  end

  sdnf_format #(
    .WIDTH    (WIDTH),
    .HAS_DOTS (HAS_DOTS)
  ) u_format (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pipe_valid[NDIG]),
    .up_stall (pipe_stall[NDIG]),
    .up_data  (pipe_data[NDIG]),
    .dn_valid (fmt_valid),
    .dn_stall (fmt_stall),
    .dn_cells (fmt_cells),
    .dn_act   (fmt_act),
    .dn_dix   (fmt_dix)
  );

  // Serializer: take a laid-out number once the previous one sent its last cell.
  assign out_fire = busy && !out_stall;
  assign done = out_fire && (cnt == LAST_CELL);
  assign load = !busy || done;
  assign fmt_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      busy <= fmt_valid;
      cnt <= '0;
    end else if (out_fire) begin
      cnt <= cnt + CIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && fmt_valid) begin
      cells <= fmt_cells;
      act <= fmt_act;
      dix <= fmt_dix;
    end
  end

  assign out_valid = busy;

  always_comb begin
    out_data.cell_index = 3'(cnt);
    out_data.glyph = cells[cnt];
    out_data.dot_action = (cnt == '0) ? act : DOT_LEAVE;
    out_data.dot_index = (cnt == '0) ? dix : 3'd0;
    out_data.last = (cnt == LAST_CELL);
  end

`ifndef SYNTH
  a_cells_in_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last) |=>
      (out_valid && out_data.cell_index == $past(out_data.cell_index) + 3'd1))
    else $error("cell order broken within a number");

  a_new_number_at_cell0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last) |=>
      (!out_valid || out_data.cell_index == 3'd0))
    else $error("next number does not start at cell 0");

  a_dot_only_cell0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.cell_index != 3'd0) |->
      (out_data.dot_action == DOT_LEAVE && out_data.dot_index == 3'd0))
    else $error("dot command outside cell 0");

  // a dot position of eight wraps to zero on displays wider than eight cells
  a_lit_dot_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dot_action == DOT_LIGHT) |->
      ((out_data.dot_index != 3'd0 || WIDTH > 8) && HAS_DOTS != 0))
    else $error("lit dot without a position");
`endif

endmodule

// File: rtl/sdnf_digit_stage.sv
// One decimal digit extraction stage of the formatter pipeline.
module sdnf_digit_stage #(
  parameter int unsigned POS = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_stall,
  input  sdnf_pkg::work_t up_data,
  output logic           dn_valid,
  input  logic           dn_stall,
  output sdnf_pkg::work_t dn_data
);
  import sdnf_pkg::*;

  logic        valid;
  work_t       data;
  work_t       data_next;
  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] quot_x10;

  always_comb begin
    prod = 64'(up_data.rem) * 64'(RECIP10);
    quot = prod[63:RECIP_SHIFT];
    quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    data_next = up_data;
    data_next.digits[POS*4 +: 4] = 4'(up_data.rem - quot_x10);
    data_next.rem = {3'b000, quot};
    if (up_data.rem != 32'd0) begin
      data_next.ndig = NDIG_W'(POS + 1);
    end
  end

  assign up_stall = valid && dn_stall;
  assign dn_valid = valid;
  assign dn_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// File: rtl/sdnf_format.sv
// Cell layout stage: turns digits and mode into glyphs and the dot command.
module sdnf_format #(
  parameter int unsigned WIDTH = sdnf_pkg::DEF_WIDTH,
  parameter int unsigned HAS_DOTS = sdnf_pkg::DEF_HAS_DOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_stall,
  input  sdnf_pkg::work_t        up_data,
  output logic                   dn_valid,
  input  logic                   dn_stall,
  output logic [WIDTH-1:0][6:0]  dn_cells,
  output logic [1:0]             dn_act,
  output logic [2:0]             dn_dix
);
  import sdnf_pkg::*;

  localparam logic [7:0] W8 = 8'(WIDTH);

  logic                  valid;
  logic [WIDTH-1:0][6:0] cells;
  logic [1:0]            act;
  logic [2:0]            dix;
  logic [WIDTH-1:0][6:0] cells_next;
  logic [1:0]            act_next;
  logic [2:0]            dix_next;

  always_comb begin
    logic [7:0] ndig8;
    logic [7:0] hexn8;
    logic [7:0] total;
    logic [7:0] pos8;
    logic       pad;
    logic       ovf;
    logic [3:0] dg;
    logic [3:0] nib;
    int         p;
    ndig8 = 8'(up_data.ndig);
    hexn8 = 8'(up_data.hexn);
    pad = (up_data.op == OP_FIXED) && (ndig8 <= up_data.dec);
    total = pad ? 8'(up_data.dec + 8'd1) : ndig8;
    case (up_data.op)
      OP_UNSIGNED: ovf = ndig8 > W8;
      OP_SIGNED:   ovf = up_data.neg ? (ndig8 > W8 - 8'd1) : (ndig8 > W8);
      OP_FIXED:    ovf = (ndig8 > W8) || (pad && up_data.dec >= W8)
                         || (up_data.neg && total >= W8);
      OP_HEX:      ovf = 1'b0;
      default:     ovf = 1'b0;
    endcase

    for (int i = 0; i < WIDTH; i++) begin
      p = WIDTH - 1 - i;
      pos8 = 8'(p);
      dg = 4'(up_data.digits >> (4 * p));
      nib = 4'(up_data.hex_val >> (4 * p));
      if (up_data.op == OP_HEX) begin
        if (pos8 < hexn8) begin
          cells_next[i] = (nib < 4'd10) ? GLYPH_ZERO + 7'(nib) : GLYPH_A + 7'(nib - 4'd10);
        end else begin
          cells_next[i] = GLYPH_SPACE;
        end
      end else if (pos8 < ndig8) begin
        cells_next[i] = GLYPH_ZERO + 7'(dg);
      end else if (pos8 < total) begin
        cells_next[i] = GLYPH_ZERO;
      end else if (up_data.neg && pos8 == total) begin
        cells_next[i] = GLYPH_MINUS;
      end else begin
        cells_next[i] = GLYPH_SPACE;
      end
      if (ovf) begin
        cells_next[i] = (i == 0 && up_data.neg) ? GLYPH_MINUS : GLYPH_NINE;
      end
    end

    act_next = DOT_LEAVE;
    dix_next = 3'd0;
    if (up_data.op == OP_FIXED && HAS_DOTS != 0) begin
      act_next = DOT_CLEAR;
      if (!ovf && up_data.dec != 8'd0 && up_data.dec < W8) begin
        act_next = DOT_LIGHT;
        dix_next = 3'(W8 - up_data.dec);
      end
    end
  end

  assign up_stall = valid && dn_stall;
  assign dn_valid = valid;
  assign dn_cells = cells;
  assign dn_act = act;
  assign dn_dix = dix;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      cells <= cells_next;
      act <= act_next;
      dix <= dix_next;
    end
  end

endmodule
